// File: sv/uetd_pkg.sv
// shared types and constants for the 8n1 edge timing decoder
package uetd_pkg;

  localparam int MAX_BIT_RUN_DEF = 10;
  localparam int CPB_W           = 29;
  localparam int TICK_W          = 32;
  localparam int ACC_W           = TICK_W + 1;
  localparam int POS_W           = 4;
  localparam int DIV_CNT_W       = 5;

  localparam logic [POS_W-1:0] POS_IDLE = 4'd15;
  localparam logic [POS_W-1:0] POS_STOP = 4'd8;

  localparam logic [1:0] OP_EDGE   = 2'd0;
  localparam logic [1:0] OP_POLL   = 2'd1;
  localparam logic [1:0] OP_RESYNC = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [TICK_W-1:0] tick;
    logic              line_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       framing_error;
    logic       coalesced_edge;
    logic       break_seen;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FEED,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MODE_EDGE,
    MODE_POLL_LOW,
    MODE_POLL_HIGH
  } mode_t;

  typedef struct packed {
    logic                 start;
    logic [ACC_W-1:0]     dividend;
    logic [CPB_W-1:0]     divisor;
    logic [DIV_CNT_W-1:0] limit;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_CNT_W-1:0] count;
  } div_rsp_t;

endpackage

// File: sv/uetd_div.sv
// shared subtract unit: counts whole bit periods in a span, up to a limit
module uetd_div import uetd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic [ACC_W-1:0]     acc;
  logic [CPB_W-1:0]     divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_CNT_W-1:0] limit;
  logic [ACC_W-1:0]     divisor_ext;
  logic                 step;

  assign divisor_ext = {{(ACC_W-CPB_W){1'b0}}, divisor};
  assign step        = busy && (cnt < limit) && (acc >= divisor_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (busy && !step) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc     <= req.dividend;
      divisor <= req.divisor;
      limit   <= req.limit;
      cnt     <= '0;
    end else if (step) begin
      acc <= acc - divisor_ext;
      cnt <= cnt + 1'b1;
    end
  end

  assign rsp.done  = busy && !step;
  assign rsp.count = cnt;

endmodule

// File: sv/uart_8n1_edge_timing_decoder.sv
// uart 8n1 decoder driven by timestamped line transitions
// items that need no run length go straight to the finish state; otherwise the shared
// subtract unit takes one bit period per cycle, then up to three framer steps follow and the
// result is loaded into the output register, once a stalled result no longer holds it
// throughput: one item at a time; a finished result waits in the output register while the
// next item is taken
// reset (rst, synchronous): decoder disabled, line idle high, awaiting start bit.
module uart_8n1_edge_timing_decoder import uetd_pkg::*; #(
  parameter int MAX_BIT_RUN = MAX_BIT_RUN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CPB_W-1:0] cfg_data
);

  localparam logic [DIV_CNT_W-1:0] RUN_MAX   = DIV_CNT_W'(MAX_BIT_RUN);
  localparam logic [DIV_CNT_W-1:0] RUN_BREAK = DIV_CNT_W'(MAX_BIT_RUN + 1);

  state_t state, state_next;
  mode_t  mode;

  logic [CPB_W-1:0]     cpb;
  logic [TICK_W-1:0]    last_tick;
  logic                 held;
  logic [POS_W-1:0]     pos;
  logic [7:0]           shift_byte;
  logic                 brk;

  logic [TICK_W-1:0]    tick_r;
  logic                 lvl_r;
  logic                 feed_lvl;
  logic [DIV_CNT_W-1:0] bits;
  out_item_t            res;

  logic                 accept;
  logic                 load_out;
  logic                 go_div;
  mode_t                go_mode;
  logic                 post_feed;
  logic                 feed_end;
  logic [TICK_W-1:0]    delta;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic [POS_W-1:0]     room;
  logic [POS_W-1:0]     take;
  logic [7:0]           shift_fed;

  uetd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign delta = in_data.tick - last_tick;

  // what an accepted item needs from the subtract unit
  always_comb begin
    go_div           = 1'b0;
    go_mode          = MODE_EDGE;
    div_req.dividend = {1'b0, delta};
    div_req.divisor  = cpb;
    div_req.limit    = RUN_MAX;
    if (cpb != '0 && !brk) begin
      case (in_data.opcode)
        OP_EDGE: begin
          if (in_data.line_level != held) begin
            go_div           = 1'b1;
            // round to nearest bit period
            div_req.dividend = {1'b0, delta} + {{(ACC_W-CPB_W+1){1'b0}}, cpb[CPB_W-1:1]};
          end
        end
        OP_POLL: begin
          if (!held) begin
            go_div        = 1'b1;
            go_mode       = MODE_POLL_LOW;
            div_req.limit = RUN_BREAK;
          end else if (pos <= POS_STOP && in_data.line_level) begin
            go_div  = 1'b1;
            go_mode = MODE_POLL_HIGH;
          end
        end
        default: begin
          go_div = 1'b0;
        end
      endcase
    end
    div_req.start = accept && go_div;
  end

  // one framer step
  always_comb begin
    room      = POS_STOP - pos;
    take      = ({1'b0, bits[DIV_CNT_W-2:0]} < {1'b0, room} && !bits[DIV_CNT_W-1])
                ? bits[POS_W-1:0] : room;
    shift_fed = (shift_byte >> take) | (feed_lvl ? (8'hFF << (POS_STOP - take)) : 8'h00);
    feed_end  = (bits == '0) || (pos > POS_STOP && feed_lvl) || (pos == POS_STOP);
    post_feed = (mode == MODE_EDGE) ||
                (mode == MODE_POLL_HIGH && div_rsp.count == RUN_MAX && lvl_r);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = go_div ? ST_DIV : ST_FINISH;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = post_feed ? ST_FEED : ST_FINISH;
        end
      end
      ST_FEED: begin
        if (feed_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = (state != ST_IDLE);
    accept        = in_valid && (state == ST_IDLE);
    load_out      = (state == ST_FINISH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cpb        <= '0;
      last_tick  <= '0;
      held       <= 1'b1;
      pos        <= POS_IDLE;
      shift_byte <= '0;
      brk        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_data.opcode)
              OP_RESYNC: begin
                last_tick  <= in_data.tick;
                held       <= in_data.line_level;
                pos        <= POS_IDLE;
                shift_byte <= '0;
                brk        <= 1'b0;
              end
              OP_EDGE: begin
                if (cpb != '0) begin
                  if (brk) begin
                    if (in_data.line_level) begin
                      brk <= 1'b0;
                    end
                    last_tick <= in_data.tick;
                    held      <= in_data.line_level;
                  end else if (in_data.line_level == held) begin
                    last_tick <= in_data.tick;
                    pos       <= POS_IDLE;
                  end else begin
                    last_tick <= in_data.tick;
                    held      <= in_data.line_level;
                  end
                end
              end
              OP_POLL: begin
                if (cpb != '0 && brk && in_data.line_level) begin
                  brk       <= 1'b0;
                  held      <= 1'b1;
                  last_tick <= in_data.tick;
                end
              end
              default: begin
                brk <= brk;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            case (mode)
              MODE_POLL_LOW: begin
                if (div_rsp.count == RUN_BREAK) begin
                  if (lvl_r) begin
                    held <= 1'b1;
                  end else begin
                    brk <= 1'b1;
                  end
                  pos        <= POS_IDLE;
                  shift_byte <= '0;
                  last_tick  <= tick_r;
                end
              end
              MODE_POLL_HIGH: begin
                if (post_feed) begin
                  last_tick <= tick_r;
                end
              end
              default: begin
                brk <= brk;
              end
            endcase
          end
        end
        ST_FEED: begin
          if (bits != '0) begin
            if (pos > POS_STOP) begin
              if (!feed_lvl) begin
                pos        <= '0;
                shift_byte <= '0;
              end
            end else if (pos < POS_STOP) begin
              shift_byte <= shift_fed;
              pos        <= pos + take;
            end else begin
              pos <= POS_IDLE;
            end
          end
        end
        default: begin
          brk <= brk;
        end
      endcase
      if (cfg_we) begin
        cpb        <= cfg_data;
        pos        <= POS_IDLE;
        shift_byte <= '0;
        brk        <= 1'b0;
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          tick_r   <= in_data.tick;
          lvl_r    <= in_data.line_level;
          mode     <= go_mode;
          feed_lvl <= (go_mode == MODE_POLL_HIGH) ? 1'b1 : held;
          // only a same-level transition reports at accept time
          res      <= {10'h000, (in_data.opcode == OP_EDGE && cpb != '0 && !brk &&
                                 in_data.line_level == held), 1'b0};
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          bits <= (mode == MODE_POLL_HIGH) ? RUN_MAX : div_rsp.count;
          if (mode == MODE_POLL_LOW && div_rsp.count == RUN_BREAK) begin
            if (lvl_r) begin
              res.coalesced_edge <= 1'b1;
            end else begin
              res.break_seen <= 1'b1;
            end
          end
        end
      end
      ST_FEED: begin
        if (bits != '0) begin
          if (pos > POS_STOP) begin
            if (!feed_lvl) begin
              bits <= bits - 1'b1;
            end
          end else if (pos < POS_STOP) begin
            bits <= bits - {{(DIV_CNT_W-POS_W){1'b0}}, take};
          end else if (feed_lvl) begin
            res.byte_valid <= 1'b1;
            res.data_byte  <= shift_byte;
          end else begin
            res.framing_error <= 1'b1;
          end
        end
      end
      default: begin
        res <= res;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({out_data.byte_valid, out_data.framing_error,
                            out_data.coalesced_edge, out_data.break_seen}))
    else $error("more than one result flag set");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.byte_valid) |-> (out_data.data_byte == 8'h00))
    else $error("data byte nonzero without byte_valid");

  a_pos_legal: assert property (@(posedge clk) disable iff (rst)
    (pos <= POS_STOP) || (pos == POS_IDLE))
    else $error("frame position out of range");

  a_break_idle: assert property (@(posedge clk) disable iff (rst)
    brk |-> (pos == POS_IDLE))
    else $error("frame in progress during break hold");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_rsp.done) |-> (div_rsp.count <= RUN_BREAK))
    else $error("run count beyond limit");
`endif

endmodule

// File: bench/tb.sv
// self-checking testbench for the 8n1 edge timing decoder
module tb;
  import uetd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  // decode predictor with the expected-result store
  class frame_scoreboard;
    logic [CPB_W-1:0]  cpb;
    logic [TICK_W-1:0] last_edge;
    logic              held;
    logic              brk;
    logic [POS_W-1:0]  pos;
    logic [7:0]        shreg;
    out_item_t         res;
    out_item_t         decode_q[$];
    int                errors;

    function new();
      cpb       = '0;
      last_edge = '0;
      held      = 1'b1;
      errors    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos   = POS_IDLE;
      shreg = '0;
      brk   = 1'b0;
    endfunction

    function void write_cpb(logic [CPB_W-1:0] v);
      cpb = v;
      clear_frame();
    endfunction

    // rounded bit count of a run, clamped at the longest run
    function int unsigned bit_run(logic [TICK_W-1:0] delta);
      logic [63:0] span;
      logic [63:0] q;
      span = 64'(cpb) * 64'(MAX_BIT_RUN_DEF);
      if (64'(delta) >= span) return MAX_BIT_RUN_DEF;
      q = (64'(delta) + 64'(cpb >> 1)) / 64'(cpb);
      if (q > 64'(MAX_BIT_RUN_DEF)) q = 64'(MAX_BIT_RUN_DEF);
      return int'(q);
    endfunction

    function void shift_in(int unsigned nbits, logic lvl);
      int unsigned room;
      int unsigned take;
      while (nbits > 0) begin
        if (pos > POS_STOP) begin
          // idle high run left over after a frame is dropped
          if (lvl) return;
          pos   = '0;
          shreg = '0;
          nbits--;
        end else if (pos < POS_STOP) begin
          room  = 32'(POS_STOP - pos);
          take  = (nbits < room) ? nbits : room;
          shreg = shreg >> take;
          if (lvl) shreg = shreg | (8'hFF << (8 - take));
          pos   = pos + POS_W'(take);
          nbits = nbits - take;
        end else begin
          if (lvl) begin
            res.data_byte  = shreg;
            res.byte_valid = 1'b1;
          end else begin
            res.framing_error = 1'b1;
          end
          pos = POS_IDLE;
          return;
        end
      end
    endfunction

    function void note_event(in_item_t it);
      logic [TICK_W-1:0] delta;
      logic [63:0]       span;
      logic              prev;
      res   = '0;
      delta = it.tick - last_edge;
      span  = 64'(cpb) * 64'(MAX_BIT_RUN_DEF);
      if (it.opcode == OP_RESYNC) begin
        last_edge = it.tick;
        held      = it.line_level;
        clear_frame();
      end else if (it.opcode == OP_UNUSED || cpb == '0) begin
        // no effect
      end else if (it.opcode == OP_EDGE) begin
        if (brk) begin
          if (it.line_level) brk = 1'b0;
          last_edge = it.tick;
          held      = it.line_level;
        end else if (it.line_level == held) begin
          res.coalesced_edge = 1'b1;
          last_edge          = it.tick;
          pos                = POS_IDLE;
        end else begin
          prev      = held;
          last_edge = it.tick;
          held      = it.line_level;
          shift_in(bit_run(delta), prev);
        end
      end else begin
        if (brk) begin
          if (it.line_level) begin
            brk       = 1'b0;
            held      = 1'b1;
            last_edge = it.tick;
          end
        end else if (held && pos > POS_STOP) begin
          // idle high, nothing pending
        end else if (!held) begin
          if (64'(delta) >= span + 64'(cpb)) begin
            // missed rising edge if high now, break if still low
            if (it.line_level) begin
              res.coalesced_edge = 1'b1;
              held               = 1'b1;
            end else begin
              res.break_seen = 1'b1;
              brk            = 1'b1;
            end
            pos       = POS_IDLE;
            shreg     = '0;
            last_edge = it.tick;
          end
        end else if (64'(delta) >= span && it.line_level) begin
          last_edge = it.tick;
          shift_in(MAX_BIT_RUN_DEF, 1'b1);
        end
      end
      decode_q.push_back(res);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_decode(out_item_t got);
      out_item_t want;
      if (decode_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = decode_q.pop_front();
      check_field("data_byte", want.data_byte, got.data_byte);
      check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      check_field("framing_error", 8'(want.framing_error), 8'(got.framing_error));
      check_field("coalesced_edge", 8'(want.coalesced_edge), 8'(got.coalesced_edge));
      check_field("break_seen", 8'(want.break_seen), 8'(got.break_seen));
    endfunction
  endclass

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CPB_W-1:0] cfg_data  = '0;

  frame_scoreboard sb = new();

  logic [CPB_W-1:0]  cur_cpb  = '0;
  logic [TICK_W-1:0] line_now = '0;
  logic              line_lvl = 1'b1;
  int                burst_left = 0;
  bit                no_gap     = 1'b0;
  int                sent_items = 0;

  uart_8n1_edge_timing_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // receiver: checks each transfer, stalls in segments, with two long hold-offs
  initial begin
    int hold_left;
    int seg_left;
    int stall_pct;
    int got_count;
    hold_left = 0;
    seg_left  = 0;
    stall_pct = 0;
    got_count = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_decode(out_data);
        got_count++;
        if (got_count == 150 || got_count == 1000) hold_left = 400;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 120);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          3:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic emit(input logic [1:0] op, input logic [TICK_W-1:0] tk, input logic lvl);
    in_item_t it;
    int       gap;
    it.opcode     = op;
    it.tick       = tk;
    it.line_level = lvl;
    if (burst_left == 0) begin
      gap = no_gap ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_event(it);
    sent_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.decode_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_cpb(input logic [CPB_W-1:0] v);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.write_cpb(v);
    cur_cpb = v;
  endtask

  // n bit periods after base, with a little jitter on each edge
  function automatic logic [TICK_W-1:0] bit_time(logic [TICK_W-1:0] base, int unsigned n);
    logic [TICK_W-1:0] spread;
    logic [TICK_W-1:0] jit;
    spread = TICK_W'(cur_cpb) >> 2;
    jit    = (spread == 0) ? '0 : $urandom_range(0, spread) - (spread >> 1);
    return base + TICK_W'(n) * TICK_W'(cur_cpb) + jit;
  endfunction

  // one 8n1 frame as line transitions, lead bits of idle high before the start bit
  task automatic send_frame(input logic [7:0] b, input bit stop_ok, input int unsigned lead);
    logic [9:0]        levels;
    logic              prev;
    logic [TICK_W-1:0] base;
    int unsigned       extra;
    if (!line_lvl) begin
      emit(OP_EDGE, bit_time(line_now, 1), 1'b1);
      line_now = line_now + TICK_W'(cur_cpb);
      line_lvl = 1'b1;
    end
    base   = line_now + TICK_W'(lead) * TICK_W'(cur_cpb);
    levels = {stop_ok, b, 1'b0};
    prev   = 1'b1;
    for (int k = 0; k < 10; k++) begin
      if (levels[k] != prev) begin
        emit(OP_EDGE, bit_time(base, k), levels[k]);
        prev = levels[k];
      end
    end
    extra    = 0;
    if (!stop_ok) begin
      extra = $urandom_range(0, 2);
      emit(OP_EDGE, bit_time(base, 10 + extra), 1'b1);
    end
    line_now = base + TICK_W'(10 + extra) * TICK_W'(cur_cpb);
    line_lvl = 1'b1;
  endtask

  // line held low, polled, maybe into a break, then released
  task automatic send_low_stretch();
    logic [TICK_W-1:0] base;
    int unsigned       n;
    base = bit_time(line_now, $urandom_range(0, 5));
    emit(OP_EDGE, base, 1'b0);
    n = 0;
    repeat ($urandom_range(1, 3)) begin
      n = n + $urandom_range(2, 9);
      emit(OP_POLL, bit_time(base, n), 1'b0);
    end
    n = n + $urandom_range(0, 8);
    if ($urandom_range(0, 1)) emit(OP_EDGE, bit_time(base, n), 1'b0);
    n = n + $urandom_range(1, 4);
    if ($urandom_range(0, 1)) emit(OP_EDGE, bit_time(base, n), 1'b1);
    else emit(OP_POLL, bit_time(base, n), 1'b1);
    line_now = base + TICK_W'(n) * TICK_W'(cur_cpb);
    line_lvl = 1'b1;
  endtask

  task automatic send_random_sequence();
    int                sel;
    logic [TICK_W-1:0] tk;
    logic              lvl;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0,
                 $urandom_range(0, 13));
      if ($urandom_range(0, 3) == 0)
        emit(OP_POLL, bit_time(line_now, $urandom_range(0, 14)), 1'b1);
    end else if (sel < 70) begin
      send_low_stretch();
    end else if (sel < 78) begin
      // transition at the same level
      tk = bit_time(line_now, $urandom_range(0, 12));
      emit(OP_EDGE, tk, line_lvl);
      line_now = tk;
    end else if (sel < 85) begin
      lvl = ($urandom_range(0, 3) == 0) ? ~line_lvl : line_lvl;
      emit(OP_POLL, bit_time(line_now, $urandom_range(0, 14)), lvl);
    end else if (sel < 95) begin
      emit(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
    end else begin
      tk  = $urandom;
      lvl = 1'($urandom_range(0, 1));
      emit(OP_RESYNC, tk, lvl);
      line_now = tk;
      line_lvl = lvl;
    end
  endtask

  initial begin
    logic [TICK_W-1:0] base;
    logic [CPB_W-1:0]  v;
    int                phase_end;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // decoder disabled after reset, resync still taken
    emit(OP_EDGE, 32'hFFFF_FFFF, 1'b0);
    emit(OP_POLL, 32'h0000_0000, 1'b1);
    emit(OP_UNUSED, 32'hFFFF_FFFF, 1'b1);
    emit(OP_RESYNC, 32'hFFFF_FF80, 1'b1);
    line_now = 32'hFFFF_FF80;
    line_lvl = 1'b1;

    set_cpb(CPB_W'(16));
    // frames across the tick wrap, the third one finished by an idle poll
    send_frame(8'h00, 1'b1, 2);
    send_frame(8'hFF, 1'b1, 0);
    send_frame(8'h80, 1'b1, 1);
    emit(OP_POLL, bit_time(line_now, 12), 1'b1);
    send_frame(8'h0F, 1'b0, 1);
    emit(OP_EDGE, bit_time(line_now, 3), 1'b1);
    line_now = line_now + 3 * 16;
    // break, transition while held, poll high releases
    base = bit_time(line_now, 2);
    emit(OP_EDGE, base, 1'b0);
    emit(OP_POLL, base + 5 * 16, 1'b0);
    emit(OP_POLL, base + 12 * 16, 1'b0);
    emit(OP_EDGE, base + 14 * 16, 1'b0);
    emit(OP_POLL, base + 16 * 16, 1'b1);
    // missed rising edge seen by a late poll
    base = base + 20 * 16;
    emit(OP_EDGE, base, 1'b0);
    emit(OP_POLL, base + 12 * 16, 1'b1);
    emit(OP_UNUSED, base + 13 * 16, 1'b0);
    line_now = base + 13 * 16;

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0:       v = CPB_W'(1);
        1:       v = CPB_W'(2);
        2:       v = CPB_W'(3);
        3:       v = CPB_W'(0);
        4:       v = 29'h1FFF_FFFF;
        5:       v = CPB_W'($urandom_range(4, 64));
        6:       v = CPB_W'($urandom_range(65, 100000));
        7:       v = CPB_W'($urandom_range(29'h0100_0000, 29'h1FFF_FFFE));
        default: v = CPB_W'($urandom_range(5, 20));
      endcase
      set_cpb(v);
      no_gap = ($urandom_range(0, 2) == 0);
      line_now = $urandom;
      line_lvl = 1'b1;
      emit(OP_RESYNC, line_now, 1'b1);
      phase_end = sent_items + 200;
      while (sent_items < phase_end) send_random_sequence();
    end

    wait_drained();
    repeat (MAX_BIT_RUN_DEF + 20) @(posedge clk);
    if (sb.errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

// File: sim.f
sv/uetd_pkg.sv
sv/uetd_div.sv
sv/uart_8n1_edge_timing_decoder.sv
bench/tb.sv
